>>> hdl/cfa_pkg.sv
// shared types and constants for the contiguous fit allocator
// no dependencies; imported by cfa_ram, cfa_ctrl and contiguous_fit_allocator
`timescale 1ns / 1ps

package cfa_pkg;

	localparam int CELLS    = 64;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int CNT_W    = $clog2(CELLS + 1);

	localparam int OP_W     = 2;
	localparam int SIZE_W   = 7;
	localparam int OWNER_W  = 8;
	localparam int RSTART_W = 6;
	localparam int START_W  = 6;
	localparam int LEN_W    = 7;
	localparam int STAT_W   = 2;
	localparam int POL_W    = 2;

	localparam logic [OWNER_W-1:0] TAG_FREE     = 8'h00;
	localparam logic [OWNER_W-1:0] TAG_RESERVED = 8'hFF;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	localparam logic [POL_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [POL_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [POL_W-1:0] FIT_WORST = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FIT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD    = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [SIZE_W-1:0]   size;
		logic [OWNER_W-1:0]  owner;
		logic [RSTART_W-1:0] rstart;
	} req_t;

	typedef struct packed {
		logic                granted;
		logic [START_W-1:0]  start;
		logic [LEN_W-1:0]    length;
		logic [STAT_W-1:0]   status;
	} res_t;

	typedef struct packed {
		logic                clr;
		logic                wr_en;
		logic [ADDR_W-1:0]   wr_addr;
		logic [OWNER_W-1:0]  wr_data;
		logic                rd_en;
		logic [ADDR_W-1:0]   rd_addr;
	} ram_req_t;

endpackage

>>> hdl/cfa_ram.sv
// owner tag memory: one write port, one registered read port, per-entry valid bits
// depends on cfa_pkg
`timescale 1ns / 1ps

module cfa_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfa_pkg::ram_req_t         req,
	output logic [cfa_pkg::OWNER_W-1:0] rd_data
);
	import cfa_pkg::*;

	logic [OWNER_W-1:0] mem [CELLS];
	logic [CELLS-1:0]   valid_q;
	logic [OWNER_W-1:0] rd_data_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// an entry never written since reset or clear reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : TAG_FREE;

endmodule

>>> hdl/cfa_ctrl.sv
// request sequencer: for an allocate, hole scan over the owner memory, then a write pass;
// a reserve takes the write pass alone; depends on cfa_pkg; drives cfa_ram through a ram_req_t
`timescale 1ns / 1ps

module cfa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [cfa_pkg::POL_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cfa_pkg::req_t               req,
	output cfa_pkg::ram_req_t           ram_req,
	input  logic [cfa_pkg::OWNER_W-1:0] rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output cfa_pkg::res_t               res
);
	import cfa_pkg::*;

	state_t              state_q, state_d;
	logic [POL_W-1:0]    policy_q;
	req_t                req_q;
	res_t                res_q;

	logic [CNT_W-1:0]    scan_addr_q;
	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   rd_idx_s1;
	logic [ADDR_W-1:0]   hs_q, bs_q;
	logic [CNT_W-1:0]    hl_q, bl_q;
	logic                found_q;

	logic [ADDR_W-1:0]   wr_addr_q;
	logic [SIZE_W-1:0]   wr_left_q;
	logic [OWNER_W-1:0]  wr_data_q;

	logic                in_acc;
	logic                size_bad, range_bad, go_alloc, go_reserve;
	logic                rd_issue, scan_last;
	logic                cell_free;
	logic [ADDR_W-1:0]   hs_new, cand_s, bs_d;
	logic [CNT_W-1:0]    hl_new, cand_l, bl_d;
	logic                cand_en, fits, take, found_d;

	assign in_acc = in_valid && (state_q == S_IDLE);

	// request checks
	assign size_bad   = (req.size == '0) || (32'(req.size) > 32'(CELLS));
	assign range_bad  = (32'(req.rstart) + 32'(req.size)) > 32'(CELLS);
	assign go_alloc   = (req.op == OP_ALLOC) && !size_bad && (req.owner != TAG_FREE);
	assign go_reserve = (req.op == OP_RESERVE) && !size_bad && !range_bad;

	assign rd_issue  = (state_q == S_SCAN) && (scan_addr_q != CNT_W'(CELLS));
	assign scan_last = rd_vld_s1 && (rd_idx_s1 == ADDR_W'(CELLS - 1));

	// hole tracking on the cell that just came back from memory
	always_comb begin
		cell_free = (rd_data == TAG_FREE);
		hs_new    = (hl_q == '0) ? rd_idx_s1 : hs_q;
		hl_new    = hl_q + CNT_W'(1);
		// an occupied cell closes the running hole; the last cell closes it too
		cand_en   = rd_vld_s1 && (!cell_free || scan_last);
		cand_s    = cell_free ? hs_new : hs_q;
		cand_l    = cell_free ? hl_new : hl_q;
		fits      = 32'(cand_l) >= 32'(req_q.size);
		take      = cand_en && fits &&
			(!found_q ||
			 ((policy_q == FIT_BEST) && (cand_l < bl_q)) ||
			 ((policy_q == FIT_WORST) && (cand_l > bl_q)));
		found_d   = found_q || take;
		bs_d      = take ? cand_s : bs_q;
		bl_d      = take ? cand_l : bl_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (go_alloc) begin
						state_d = S_SCAN;
					end else if (go_reserve) begin
						state_d = S_WRITE;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = found_d ? S_WRITE : S_RESP;
				end
			end
			S_WRITE: begin
				if (wr_left_q == SIZE_W'(1)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready        = (state_q == S_IDLE);
		ram_req.clr     = in_acc && (req.op == OP_CLEAR);
		ram_req.wr_en   = (state_q == S_WRITE);
		ram_req.wr_addr = wr_addr_q;
		ram_req.wr_data = wr_data_q;
		ram_req.rd_en   = rd_issue;
		ram_req.rd_addr = scan_addr_q[ADDR_W-1:0];
		res_valid       = (state_q == S_RESP);
		res             = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= FIT_FIRST;
			scan_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
			hl_q        <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (cfg_wr_en) begin
				policy_q <= cfg_wr_data;
			end
			if (in_acc) begin
				scan_addr_q <= '0;
				hl_q        <= '0;
				found_q     <= 1'b0;
			end else begin
				if (rd_issue) begin
					scan_addr_q <= scan_addr_q + CNT_W'(1);
				end
				if (rd_vld_s1) begin
					hl_q    <= cell_free ? hl_new : '0;
					found_q <= found_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_idx_s1 <= scan_addr_q[ADDR_W-1:0];
		end
		if (rd_vld_s1) begin
			hs_q <= cell_free ? hs_new : hs_q;
			bs_q <= bs_d;
			bl_q <= bl_d;
		end
		if (in_acc) begin
			req_q     <= req;
			wr_addr_q <= ADDR_W'(req.rstart);
			wr_left_q <= req.size;
			wr_data_q <= TAG_RESERVED;
			if (req.op == OP_CLEAR) begin
				res_q.granted <= 1'b1;
				res_q.start   <= '0;
				res_q.length  <= '0;
				res_q.status  <= STAT_OK;
			end else if (go_reserve) begin
				res_q.granted <= 1'b1;
				res_q.start   <= START_W'(req.rstart);
				res_q.length  <= LEN_W'(req.size);
				res_q.status  <= STAT_OK;
			end else begin
				res_q.granted <= 1'b0;
				res_q.start   <= '0;
				res_q.length  <= '0;
				res_q.status  <= STAT_BAD;
			end
		end else if ((state_q == S_SCAN) && scan_last) begin
			wr_addr_q <= bs_d;
			wr_data_q <= req_q.owner;
			if (found_d) begin
				res_q.granted <= 1'b1;
				res_q.start   <= START_W'(bs_d);
				res_q.length  <= LEN_W'(req_q.size);
				res_q.status  <= STAT_OK;
			end else begin
				res_q.granted <= 1'b0;
				res_q.start   <= '0;
				res_q.length  <= '0;
				res_q.status  <= STAT_NO_FIT;
			end
		end else if (state_q == S_WRITE) begin
			wr_addr_q <= wr_addr_q + ADDR_W'(1);
			wr_left_q <= wr_left_q - SIZE_W'(1);
		end
	end

endmodule

>>> hdl/contiguous_fit_allocator.sv
// allocate: full scan of 64 cells through the one memory read port, then one write per cell;
// reserve: the write pass alone; clear and rejected requests go straight to the result
// one item at a time; the next item is taken once the result enters the output register
// reset: asynchronous active low; every cell reads free at once, policy returns to first fit
// top level of the contiguous fit allocator; depends on cfa_pkg, cfa_ram, cfa_ctrl
`timescale 1ns / 1ps

module contiguous_fit_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,     // fit_policy
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,    // request_size, owner_id, range_start, zero pad
	input  logic [1:0]  s_axis_tuser,    // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata     // granted, block_start, block_length, status
);
	import cfa_pkg::*;

	req_t     req;
	res_t     res, out_q;
	ram_req_t ram_req;
	logic [OWNER_W-1:0] rd_data;
	logic     res_valid, res_ready;
	logic     out_full_q;

	always_comb begin
		req.op     = s_axis_tuser;
		req.size   = s_axis_tdata[6:0];
		req.owner  = s_axis_tdata[14:7];
		req.rstart = s_axis_tdata[20:15];
	end

	cfa_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	cfa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.req         (req),
		.ram_req     (ram_req),
		.rd_data     (rd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// output register
	assign res_ready = !out_full_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_full_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_full_q;
	assign m_axis_tdata  = {out_q.status, out_q.length, out_q.start, out_q.granted};

	// no new item while a result is still pending in the sequencer
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_axis_tready)
		else $error("item accepted while result pending");

	// the sequencer is busy in the cycle after it accepts an item
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("sequencer ready right after accepting an item");

	// a granted result always reports ok, a refused one never does
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.granted == (res.status == STAT_OK)))
		else $error("grant and status disagree");

	// clearing the memory never overlaps a write or a read of it
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.clr |-> !ram_req.wr_en && !ram_req.rd_en)
		else $error("memory clear overlaps an access");

endmodule

>>> tb/contiguous_fit_allocator_tb.sv
// self-checking testbench for contiguous_fit_allocator: allocate, reserve and clear items under
// every fit policy, checked against an in-bench model of the cell owner map
// depends on cfa_pkg and the allocator rtl
`timescale 1ns / 1ps

module contiguous_fit_allocator_tb;
	import cfa_pkg::*;

	localparam logic [OP_W-1:0]  OP_UNKNOWN = 2'd3;
	localparam logic [POL_W-1:0] FIT_SPARE  = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 140;

	typedef struct packed {
		logic               granted;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   length;
		logic [STAT_W-1:0]  status;
	} grant_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;    // request_size, owner_id, range_start, zero pad
	logic [1:0]  s_axis_tuser;    // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;    // granted, block_start, block_length, status

	// model of the allocator state
	logic [OWNER_W-1:0] cell_tag [CELLS];
	logic [POL_W-1:0]   fit_mode;
	grant_t             pending_grants[$];

	grant_t seen_grant;
	grant_t want_grant;
	int     err_count;
	int     n_requests;
	int     n_results;
	int     n_granted;
	int     n_no_fit;
	int     n_rejected;
	int     stall_count;
	int     hold_cycles;
	bit     tx_idle_on;
	bit     rx_idle_on;

	contiguous_fit_allocator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic grant_t predict_grant(input logic [OP_W-1:0] op,
			input logic [SIZE_W-1:0] size, input logic [OWNER_W-1:0] owner,
			input logic [RSTART_W-1:0] rstart);
		grant_t g;
		bit     found;
		bit     take;
		int     hs;
		int     hl;
		int     bs;
		int     bl;
		g = '0;
		found = 1'b0;
		hs = 0;
		hl = 0;
		bs = 0;
		bl = 0;
		if (op == OP_CLEAR) begin
			foreach (cell_tag[i]) cell_tag[i] = TAG_FREE;
			g.granted = 1'b1;
			g.status = STAT_OK;
			return g;
		end
		if (op == OP_UNKNOWN || size == 0 || int'(size) > CELLS) begin
			g.status = STAT_BAD;
			return g;
		end
		if (op == OP_RESERVE) begin
			if (int'(rstart) + int'(size) > CELLS) begin
				g.status = STAT_BAD;
				return g;
			end
			for (int i = int'(rstart); i < int'(rstart) + int'(size); i++)
				cell_tag[i] = TAG_RESERVED;
			g.granted = 1'b1;
			g.start = rstart;
			g.length = size;
			g.status = STAT_OK;
			return g;
		end
		if (owner == TAG_FREE) begin
			g.status = STAT_BAD;
			return g;
		end
		// index CELLS closes the last hole
		for (int i = 0; i <= CELLS; i++) begin
			if (i < CELLS && cell_tag[i] == TAG_FREE) begin
				if (hl == 0)
					hs = i;
				hl++;
			end else begin
				if (hl >= int'(size)) begin
					take = !found || (fit_mode == FIT_BEST && hl < bl) ||
						(fit_mode == FIT_WORST && hl > bl);
					if (take) begin
						found = 1'b1;
						bs = hs;
						bl = hl;
					end
				end
				hl = 0;
			end
		end
		if (!found) begin
			g.status = STAT_NO_FIT;
			return g;
		end
		for (int i = bs; i < bs + int'(size); i++)
			cell_tag[i] = owner;
		g.granted = 1'b1;
		g.start = START_W'(bs);
		g.length = size;
		g.status = STAT_OK;
		return g;
	endfunction

	// offer one request item; returns right after the edge that takes it
	task automatic send_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
			input logic [OWNER_W-1:0] owner, input logic [RSTART_W-1:0] rstart);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b000, rstart, owner, size};
		do @(posedge clk); while (!s_axis_tready);
		pending_grants.push_back(predict_grant(op, size, owner, rstart));
		n_requests++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	task automatic write_policy(input logic [POL_W-1:0] pol);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= pol;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		fit_mode = pol;
	endtask

	// size, range, owner and opcode corner cases under first fit
	task automatic test_request_corners();
		write_policy(FIT_FIRST);
		send_request(OP_ALLOC, 7'd0, 8'h01, 6'd0);
		send_request(OP_ALLOC, 7'd65, 8'h01, 6'd0);
		send_request(OP_ALLOC, 7'd127, 8'h55, 6'd63);
		send_request(OP_ALLOC, 7'd5, 8'h00, 6'd0);
		send_request(OP_UNKNOWN, 7'd5, 8'h07, 6'd3);
		send_request(OP_ALLOC, 7'd64, 8'hFF, 6'd0);
		send_request(OP_ALLOC, 7'd1, 8'h01, 6'd0);
		send_request(OP_CLEAR, 7'd0, 8'h00, 6'd0);
		send_request(OP_RESERVE, 7'd1, 8'h00, 6'd63);
		send_request(OP_RESERVE, 7'd5, 8'h00, 6'd60);
		send_request(OP_RESERVE, 7'd64, 8'h00, 6'd0);
		send_request(OP_RESERVE, 7'd0, 8'h00, 6'd0);
		send_request(OP_CLEAR, 7'd0, 8'h00, 6'd0);
		send_request(OP_ALLOC, 7'd1, 8'hFE, 6'd0);
		send_request(OP_ALLOC, 7'd10, 8'hAA, 6'd21);
		send_request(OP_RESERVE, 7'd21, 8'h00, 6'd42);
		send_request(OP_RESERVE, 7'd3, 8'h00, 6'd5);
		send_request(OP_ALLOC, 7'd30, 8'h55, 6'd0);
		send_request(OP_RESERVE, 7'd64, 8'h00, 6'd63);
		send_request(OP_ALLOC, 7'd64, 8'h02, 6'd0);
		send_request(OP_RESERVE, 7'd64, 8'h00, 6'd1);
	endtask

	// holes of 5, 3, 8 and 3 cells, then each policy picks from them
	task automatic test_policy_choice();
		logic [POL_W-1:0] pol_list [4];
		pol_list = '{FIT_BEST, FIT_WORST, FIT_FIRST, FIT_SPARE};
		foreach (pol_list[p]) begin
			write_policy(pol_list[p]);
			send_request(OP_CLEAR, 7'd0, 8'h00, 6'd0);
			send_request(OP_RESERVE, 7'd1, 8'h00, 6'd5);
			send_request(OP_RESERVE, 7'd1, 8'h00, 6'd9);
			send_request(OP_RESERVE, 7'd1, 8'h00, 6'd18);
			send_request(OP_RESERVE, 7'd42, 8'h00, 6'd22);
			send_request(OP_ALLOC, 7'd3, 8'h11, 6'd0);
			send_request(OP_ALLOC, 7'd2, 8'h22, 6'd0);
			send_request(OP_ALLOC, 7'd9, 8'h33, 6'd0);
		end
	endtask

	// receiver stalls long while back-to-back requests pile up at the input
	task automatic test_output_backpressure();
		wait_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_cycles = 400;
		for (int i = 0; i < 12; i++)
			send_request(OP_ALLOC, SIZE_W'($urandom_range(1, 4)),
				OWNER_W'($urandom_range(1, 254)), 6'd0);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int n_items);
		int pick;
		int kind;
		logic [OP_W-1:0]     op;
		logic [SIZE_W-1:0]   size;
		logic [OWNER_W-1:0]  owner;
		logic [RSTART_W-1:0] rstart;
		for (int n = 0; n < n_items; n++) begin
			if (n % 50 == 0) begin
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			op = OP_ALLOC;
			size = SIZE_W'($urandom_range(1, 12));
			owner = OWNER_W'($urandom_range(1, 255));
			rstart = RSTART_W'($urandom_range(0, 63));
			if (pick < 8)
				size = SIZE_W'($urandom_range(13, 64));
			else if (pick < 70)
				;
			else if (pick < 86) begin
				op = OP_RESERVE;
				size = SIZE_W'($urandom_range(1, 8));
			end else if (pick < 93)
				op = OP_CLEAR;
			else begin
				kind = $urandom_range(0, 4);
				case (kind)
					0: begin
						op = OP_UNKNOWN;
						size = SIZE_W'($urandom);
						owner = OWNER_W'($urandom);
					end
					1: size = '0;
					2: size = SIZE_W'($urandom_range(65, 127));
					3: owner = TAG_FREE;
					default: begin
						op = OP_RESERVE;
						size = SIZE_W'($urandom_range(65, 127));
					end
				endcase
			end
			send_request(op, size, owner, rstart);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_grant.granted = m_axis_tdata[0];
			seen_grant.start = m_axis_tdata[6:1];
			seen_grant.length = m_axis_tdata[13:7];
			seen_grant.status = m_axis_tdata[15:14];
			n_results++;
			if (pending_grants.size() == 0) begin
				err_count++;
				$display("%0t: result with none expected, actual %h", $realtime,
					seen_grant);
			end else begin
				want_grant = pending_grants.pop_front();
				if (seen_grant.granted) n_granted++;
				if (seen_grant.status == STAT_NO_FIT) n_no_fit++;
				if (seen_grant.status == STAT_BAD) n_rejected++;
				if (seen_grant.granted !== want_grant.granted ||
						seen_grant.start !== want_grant.start ||
						seen_grant.length !== want_grant.length ||
						seen_grant.status !== want_grant.status) begin
					err_count++;
					$display("%0t: mismatch g/s/l/st expected %0d/%0d/%0d/%0d %s",
						$realtime, want_grant.granted, want_grant.start,
						want_grant.length, want_grant.status, "actual");
					$display("%0t: actual %0d/%0d/%0d/%0d", $realtime,
						seen_grant.granted, seen_grant.start, seen_grant.length,
						seen_grant.status);
				end
			end
		end
	end

	// result receiver with random and long stalls
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			gap = rx_idle_on ? $urandom_range(0, 16) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					cfg_wr_en)
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		foreach (cell_tag[i]) cell_tag[i] = TAG_FREE;
		fit_mode = FIT_FIRST;
		err_count = 0;
		n_requests = 0;
		n_results = 0;
		n_granted = 0;
		n_no_fit = 0;
		n_rejected = 0;
		stall_count = 0;
		hold_cycles = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_request_corners();
		test_policy_choice();
		test_output_backpressure();
		write_policy(FIT_FIRST);
		test_random_traffic(250);
		write_policy(FIT_BEST);
		test_random_traffic(250);
		write_policy(FIT_WORST);
		test_random_traffic(250);
		write_policy(FIT_SPARE);
		test_random_traffic(250);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests over first, best, worst and spare fit policies",
			n_requests);
		$display("results %0d: %0d granted, %0d without a fitting hole, %0d rejected",
			n_results, n_granted, n_no_fit, n_rejected);
		if (err_count == 0 && pending_grants.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0t: %0d errors, %0d results still expected", $realtime, err_count,
				pending_grants.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
